[hw/rtl/sgl_pkg.sv]
// ----------------------------------------------------------------------------
// sgl_pkg: shared constants, types and ROM builders
// Widths, pipeline depths, register indexes and the log2/exp2 table contents.
// ----------------------------------------------------------------------------
package sgl_pkg;

	localparam int COLOR_FIELDS      = 3;
	localparam int COLOR_CHANNELS    = 3;
	localparam int LOG_TABLE_ENTRIES = 256;
	localparam int IDX_W             = $clog2(LOG_TABLE_ENTRIES + 1);

	localparam int SAMPLE_W = 20;
	localparam int LEVEL_W  = 21;
	localparam int GAMMA_W  = 16;
	localparam int CODE_W   = 8;
	localparam int CFG_IDX_W = 3;

	// pow unit stages, lane stages (pow + tone), full pipe (lane + output reg)
	localparam int POW_STAGES  = 9;
	localparam int LANE_STAGES = 11;
	localparam int PIPE_STAGES = 12;

	localparam logic [SAMPLE_W-1:0] Q16_MAX = 20'hFFFFF;
	localparam logic [SAMPLE_W-1:0] Q16_ONE = 20'h10000;
	localparam logic signed [GAMMA_W-1:0] GAMMA_ONE = 16'sd4096;
	localparam longint unsigned LN2_Q30 = 64'd744261118;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLACK_IN  = 3'd0,
		REG_BLACK_OUT = 3'd1,
		REG_WHITE_IN  = 3'd2,
		REG_WHITE_OUT = 3'd3,
		REG_MID_POINT = 3'd4,
		REG_GAMMA_LOW = 3'd5,
		REG_GAMMA_HIGH = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [LEVEL_W-1:0]  black_in;
		logic signed [LEVEL_W-1:0]  black_out;
		logic signed [LEVEL_W-1:0]  white_in;
		logic signed [LEVEL_W-1:0]  white_out;
		logic        [SAMPLE_W-1:0] mid_point;
		logic signed [GAMMA_W-1:0]  gamma_low;
		logic signed [GAMMA_W-1:0]  gamma_high;
	} tone_cfg_t;

	typedef logic [LOG_TABLE_ENTRIES:0][16:0] log_rom_t;
	typedef logic [LOG_TABLE_ENTRIES:0][31:0] exp_rom_t;

	// long division, only used while building the tables
	function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
		longint unsigned rem;
		longint unsigned quo;
		rem = 0;
		quo = 0;
		for (int b = 63; b >= 0; b--) begin
			rem = (rem << 1) | ((num >> b) & 64'd1);
			if (rem >= den) begin
				rem = rem - den;
				quo = quo | (64'd1 << b);
			end
		end
		return quo;
	endfunction

	// log2(1 + i/N) in Q.16, bit-serial squaring
	function automatic log_rom_t build_log_rom();
		log_rom_t rom;
		longint unsigned y;
		longint unsigned res;
		for (int i = 0; i <= LOG_TABLE_ENTRIES; i++) begin
			if (i >= LOG_TABLE_ENTRIES) begin
				rom[i] = 17'd65536;
			end else begin
				y = udiv64((longint'(LOG_TABLE_ENTRIES) + longint'(i)) << 30,
					64'(LOG_TABLE_ENTRIES));
				res = 0;
				for (int b = 0; b < 17; b++) begin
					y = (y * y) >> 30;
					res = res << 1;
					if (y >= (64'd1 << 31)) begin
						y = y >> 1;
						res = res | 64'd1;
					end
				end
				rom[i] = 17'((res + 64'd1) >> 1);
			end
		end
		return rom;
	endfunction

	// 2^(j/N) in Q2.30, Taylor series
	function automatic exp_rom_t build_exp_rom();
		exp_rom_t rom;
		longint unsigned x;
		longint unsigned z;
		longint unsigned term;
		longint unsigned sum;
		for (int j = 0; j <= LOG_TABLE_ENTRIES; j++) begin
			if (j >= LOG_TABLE_ENTRIES) begin
				rom[j] = 32'h8000_0000;
			end else begin
				x = udiv64(longint'(j) << 30, 64'(LOG_TABLE_ENTRIES));
				z = (x * LN2_Q30) >> 30;
				term = 64'd1 << 30;
				sum = term;
				for (int k = 1; k <= 24; k++) begin
					term = udiv64((term * z) >> 30, 64'(k));
					sum = sum + term;
				end
				rom[j] = 32'(sum);
			end
		end
		return rom;
	endfunction

	localparam log_rom_t LOG_ROM = build_log_rom();
	localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

[hw/rtl/sgl_pix_if.sv]
// ----------------------------------------------------------------------------
// sgl_pix_if: pixel input channel
// Valid/ready channel carrying one linear RGB pixel per item.
// ----------------------------------------------------------------------------
interface sgl_pix_if;
	logic        valid;
	logic        ready;
	logic [19:0] red_in;
	logic [19:0] green_in;
	logic [19:0] blue_in;
	logic        frame_end_in;

	modport source (output valid, red_in, green_in, blue_in, frame_end_in, input ready);
	modport sink (input valid, red_in, green_in, blue_in, frame_end_in, output ready);
endinterface

[hw/rtl/sgl_code_if.sv]
// ----------------------------------------------------------------------------
// sgl_code_if: code output channel
// Valid/ready channel carrying one 8-bit RGB code triple per item.
// ----------------------------------------------------------------------------
interface sgl_code_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_code;
	logic [7:0] green_code;
	logic [7:0] blue_code;
	logic       frame_end_out;

	modport source (output valid, red_code, green_code, blue_code, frame_end_out, input ready);
	modport sink (input valid, red_code, green_code, blue_code, frame_end_out, output ready);
endinterface

[hw/rtl/split_gamma_levels_correction.sv]
// ----------------------------------------------------------------------------
// split_gamma_levels_correction: two-segment gamma and levels tone curve
// Linear Q4.16 RGB pixels in, saturated 8-bit RGB codes out.
// ----------------------------------------------------------------------------
// Usage:
//  - pix_in takes one pixel per item (valid/ready); code_out gives one code
//    triple per item, in order, frame_end passed along unchanged.
//  - Twelve register stages: code_out.valid rises once the item has moved
//    from the accepting stage through to the output register. Throughput
//    is one pixel per clock while code_out does not stall, set by the fully
//    pipelined power unit in each lane.
//  - Each color has its own lane; two more power units evaluate the mid point
//    under both gammas in step with the pixel for the continuity offset.
//  - Registers are written via cfg_we/cfg_index/cfg_data; unknown indexes are
//    ignored. Write only while no item is in flight: the block does not enforce it.
//  - Reset clears all valid bits and loads the default curve (identity
//    gamma, black 0, white 1.0, mid 0.5). No clearing pass is needed.
//  - When code_out stalls, items pile up in empty stages first; pix_in.ready
//    drops only once every stage is occupied.
// ----------------------------------------------------------------------------
module split_gamma_levels_correction import sgl_pkg::*; #(
	parameter int COLOR_CHANNELS = sgl_pkg::COLOR_CHANNELS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEVEL_W-1:0]   cfg_data,
	sgl_pix_if.sink              pix_in,
	sgl_code_if.source           code_out
);

	// configuration registers
	tone_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.black_in   <= '0;
			cfg_q.black_out  <= '0;
			cfg_q.white_in   <= 21'sd65536;
			cfg_q.white_out  <= 21'sd65536;
			cfg_q.mid_point  <= 20'd32768;
			cfg_q.gamma_low  <= GAMMA_ONE;
			cfg_q.gamma_high <= GAMMA_ONE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLACK_IN:   cfg_q.black_in   <= cfg_data;
				REG_BLACK_OUT:  cfg_q.black_out  <= cfg_data;
				REG_WHITE_IN:   cfg_q.white_in   <= cfg_data;
				REG_WHITE_OUT:  cfg_q.white_out  <= cfg_data;
				REG_MID_POINT:  cfg_q.mid_point  <= cfg_data[SAMPLE_W-1:0];
				REG_GAMMA_LOW:  cfg_q.gamma_low  <= cfg_data[GAMMA_W-1:0];
				REG_GAMMA_HIGH: cfg_q.gamma_high <= cfg_data[GAMMA_W-1:0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage loads when empty or when its item moves on
	logic [PIPE_STAGES:1] vld_q;
	logic [PIPE_STAGES:1] en;
	logic [PIPE_STAGES:1] fe_q;

	always_comb begin
		en[PIPE_STAGES] = !vld_q[PIPE_STAGES] || code_out.ready;
		for (int k = PIPE_STAGES - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign pix_in.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= pix_in.valid;
			end
			for (int k = 2; k <= PIPE_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			fe_q[1] <= pix_in.frame_end_in;
		end
		for (int k = 2; k <= PIPE_STAGES; k++) begin
			if (en[k]) begin
				fe_q[k] <= fe_q[k-1];
			end
		end
	end

	// mid point under both gammas, aligned with the lanes' power output
	logic [SAMPLE_W-1:0] pm_lo, pm_hi;

	sgl_pow u_pow_mid_lo (
		.clk (clk),
		.en  (en[POW_STAGES:1]),
		.x   (cfg_q.mid_point),
		.g   (cfg_q.gamma_low),
		.y   (pm_lo)
	);

	sgl_pow u_pow_mid_hi (
		.clk (clk),
		.en  (en[POW_STAGES:1]),
		.x   (cfg_q.mid_point),
		.g   (cfg_q.gamma_high),
		.y   (pm_hi)
	);

	// color lanes
	logic [SAMPLE_W-1:0] samp [COLOR_FIELDS];
	logic [CODE_W-1:0]   code [COLOR_FIELDS];

	assign samp[0] = pix_in.red_in;
	assign samp[1] = pix_in.green_in;
	assign samp[2] = pix_in.blue_in;

	for (genvar c = 0; c < COLOR_FIELDS; c++) begin : g_lane
		if (c < COLOR_CHANNELS) begin : g_on
			sgl_lane u_lane (
				.clk   (clk),
				.en    (en[LANE_STAGES:1]),
				.cfg   (cfg_q),
				.x     (samp[c]),
				.pm_lo (pm_lo),
				.pm_hi (pm_hi),
				.code  (code[c])
			);
		end else begin : g_off
			assign code[c] = '0;
		end
	end

	// merge: output register holding the finished triple
	logic [CODE_W-1:0] code_s12 [COLOR_FIELDS];

	always_ff @(posedge clk) begin
		if (en[PIPE_STAGES]) begin
			for (int c = 0; c < COLOR_FIELDS; c++) begin
				code_s12[c] <= code[c];
			end
		end
	end

	assign code_out.valid         = vld_q[PIPE_STAGES];
	assign code_out.red_code      = code_s12[0];
	assign code_out.green_code    = code_s12[1];
	assign code_out.blue_code     = code_s12[2];
	assign code_out.frame_end_out = fe_q[PIPE_STAGES];

endmodule

[hw/rtl/sgl_pow.sv]
// ----------------------------------------------------------------------------
// sgl_pow: pipelined fixed-point power x^g
// log2 ROM, multiply by exponent, exp2 ROM; Q4.16 in, saturated Q4.16 out.
// ----------------------------------------------------------------------------
module sgl_pow import sgl_pkg::*; (
	input  logic                       clk,
	input  logic [POW_STAGES:1]        en,
	input  logic [SAMPLE_W-1:0]        x,
	input  logic signed [GAMMA_W-1:0]  g,
	output logic [SAMPLE_W-1:0]        y
);

	// early-out result carried alongside the datapath
	logic [POW_STAGES:1]    spec_q;
	logic [SAMPLE_W-1:0]    spec_val_q [POW_STAGES:1];

	logic [4:0]             p_c;
	logic [50:0]            mant_c;
	logic                   spec_c;
	logic [SAMPLE_W-1:0]    spec_val_c;

	always_comb begin
		p_c = '0;
		for (int b = 1; b < SAMPLE_W; b++) begin
			if (x[b]) begin
				p_c = 5'(b);
			end
		end
		mant_c = {31'b0, x} << (5'd31 - p_c);
		spec_c = 1'b1;
		spec_val_c = '0;
		if (g == '0) begin
			spec_val_c = Q16_ONE;
		end else if (g == GAMMA_ONE) begin
			spec_val_c = x;
		end else if (x == '0) begin
			spec_val_c = g[GAMMA_W-1] ? Q16_MAX : '0;
		end else begin
			spec_c = 1'b0;
		end
	end

	// s1: normalize
	logic [30:0]               frac_s1;
	logic [4:0]                p_s1, p_s2, p_s3;
	logic signed [GAMMA_W-1:0] g_s1, g_s2, g_s3, g_s4;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			frac_s1 <= mant_c[30:0];
			p_s1 <= p_c;
			g_s1 <= g;
		end
	end

	// s2: table position
	logic [43:0]      pos_c;
	logic [IDX_W-1:0] i_s2;
	logic [30:0]      r_s2, r_s3;

	assign pos_c = {13'b0, frac_s1} * 44'(LOG_TABLE_ENTRIES);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			i_s2 <= pos_c[31 +: IDX_W];
			r_s2 <= pos_c[30:0];
			p_s2 <= p_s1;
			g_s2 <= g_s1;
		end
	end

	// s3: log ROM
	logic [16:0] le0_c, le1_c, le0_s3, ld_s3;

	assign le0_c = LOG_ROM[i_s2];
	assign le1_c = LOG_ROM[IDX_W'(i_s2 + 1'b1)];

	always_ff @(posedge clk) begin
		if (en[3]) begin
			le0_s3 <= le0_c;
			ld_s3 <= (le1_c > le0_c) ? le1_c - le0_c : '0;
			r_s3 <= r_s2;
			p_s3 <= p_s2;
			g_s3 <= g_s2;
		end
	end

	// s4: interpolate, add exponent
	logic [47:0]        ldr_c;
	logic signed [21:0] pl_c, l_c, l_s4;

	always_comb begin
		ldr_c = {31'b0, ld_s3} * {17'b0, r_s3};
		pl_c = ($signed({17'b0, p_s3}) - 22'sd16) <<< 16;
		l_c = pl_c + $signed({5'b0, le0_s3}) + $signed({5'b0, ldr_c[47:31]});
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			l_s4 <= l_c;
			g_s4 <= g_s3;
		end
	end

	// s5: scale by exponent, split integer and fraction
	logic signed [37:0] prod_c;
	logic signed [9:0]  n_c;
	logic signed [9:0]  sh_c;
	logic [15:0]        u_s5;
	logic [5:0]         sh_s5, sh_s6, sh_s7, sh_s8;

	always_comb begin
		prod_c = 38'(g_s4) * 38'(l_s4);
		n_c = prod_c[37:28];
		sh_c = 10'sd14 - n_c;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			spec_q[1] <= spec_c;
			spec_val_q[1] <= spec_val_c;
		end
		for (int k = 2; k <= POW_STAGES; k++) begin
			if (en[k]) begin
				if (k == 5 && !spec_q[4] && n_c >= 10'sd4) begin
					spec_q[k] <= 1'b1;
					spec_val_q[k] <= Q16_MAX;
				end else if (k == 5 && !spec_q[4] && n_c <= -10'sd26) begin
					spec_q[k] <= 1'b1;
					spec_val_q[k] <= '0;
				end else begin
					spec_q[k] <= spec_q[k-1];
					spec_val_q[k] <= spec_val_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			u_s5 <= prod_c[27:12];
			sh_s5 <= sh_c[5:0];
		end
	end

	// s6: exp table position
	logic [28:0]      pos2_c;
	logic [IDX_W-1:0] j_s6;
	logic [15:0]      r2_s6, r2_s7;

	assign pos2_c = {13'b0, u_s5} * 29'(LOG_TABLE_ENTRIES);

	always_ff @(posedge clk) begin
		if (en[6]) begin
			j_s6 <= pos2_c[16 +: IDX_W];
			r2_s6 <= pos2_c[15:0];
			sh_s6 <= sh_s5;
		end
	end

	// s7: exp ROM
	logic [31:0] ee0_c, ee1_c, ee0_s7, ed_s7;

	assign ee0_c = EXP_ROM[j_s6];
	assign ee1_c = EXP_ROM[IDX_W'(j_s6 + 1'b1)];

	always_ff @(posedge clk) begin
		if (en[7]) begin
			ee0_s7 <= ee0_c;
			ed_s7 <= (ee1_c > ee0_c) ? ee1_c - ee0_c : '0;
			r2_s7 <= r2_s6;
			sh_s7 <= sh_s6;
		end
	end

	// s8: interpolate
	logic [47:0] edr_c;
	logic [32:0] m_s8;

	assign edr_c = {16'b0, ed_s7} * {32'b0, r2_s7};

	always_ff @(posedge clk) begin
		if (en[8]) begin
			m_s8 <= {1'b0, ee0_s7} + {1'b0, edr_c[47:16]};
			sh_s8 <= sh_s7;
		end
	end

	// s9: denormalize and saturate
	logic [32:0]         v_c;
	logic [SAMPLE_W-1:0] y_s9;

	assign v_c = m_s8 >> sh_s8;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			if (spec_q[8]) begin
				y_s9 <= spec_val_q[8];
			end else if (v_c > 33'(Q16_MAX)) begin
				y_s9 <= Q16_MAX;
			end else begin
				y_s9 <= v_c[SAMPLE_W-1:0];
			end
		end
	end

	assign y = y_s9;

endmodule

[hw/rtl/sgl_lane.sv]
// ----------------------------------------------------------------------------
// sgl_lane: tone curve for one color channel
// Segment select, power, continuity offset, black/white levels, 8-bit code.
// ----------------------------------------------------------------------------
module sgl_lane import sgl_pkg::*; (
	input  logic                 clk,
	input  logic [LANE_STAGES:1] en,
	input  tone_cfg_t            cfg,
	input  logic [SAMPLE_W-1:0]  x,
	input  logic [SAMPLE_W-1:0]  pm_lo,
	input  logic [SAMPLE_W-1:0]  pm_hi,
	output logic [CODE_W-1:0]    code
);

	logic                      upper_c;
	logic signed [GAMMA_W-1:0] g_c;
	logic [SAMPLE_W-1:0]       pw;
	logic [POW_STAGES:1]       upper_q;

	assign upper_c = (x >= cfg.mid_point);
	assign g_c = upper_c ? cfg.gamma_high : cfg.gamma_low;

	sgl_pow u_pow (
		.clk (clk),
		.en  (en[POW_STAGES:1]),
		.x   (x),
		.g   (g_c),
		.y   (pw)
	);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			upper_q[1] <= upper_c;
		end
		for (int k = 2; k <= POW_STAGES; k++) begin
			if (en[k]) begin
				upper_q[k] <= upper_q[k-1];
			end
		end
	end

	// s10: offset for the upper segment, saturate on top
	logic signed [22:0] sum_c;
	logic signed [21:0] y_s10, v_s11;

	assign sum_c = $signed({3'b0, pw}) + $signed({3'b0, pm_lo}) - $signed({3'b0, pm_hi});

	always_ff @(posedge clk) begin
		if (en[POW_STAGES+1]) begin
			if (!upper_q[POW_STAGES]) begin
				y_s10 <= $signed({2'b0, pw});
			end else if (sum_c > $signed({3'b0, Q16_MAX})) begin
				y_s10 <= $signed({2'b0, Q16_MAX});
			end else begin
				y_s10 <= sum_c[21:0];
			end
		end
	end

	// s11: levels
	always_ff @(posedge clk) begin
		if (en[POW_STAGES+2]) begin
			if (y_s10 <= 22'(cfg.black_in)) begin
				v_s11 <= 22'(cfg.black_out);
			end else if (y_s10 >= 22'(cfg.white_in)) begin
				v_s11 <= 22'(cfg.white_out);
			end else begin
				v_s11 <= y_s10;
			end
		end
	end

	// code: floor(v*255/65536), clamped
	logic [29:0] sc_c;

	always_comb begin
		sc_c = 30'(v_s11[20:0]) * 30'd255;
		if (v_s11 <= 22'sd0) begin
			code = '0;
		end else if (sc_c[29:16] > 14'd255) begin
			code = 8'hFF;
		end else begin
			code = sc_c[23:16];
		end
	end

endmodule

[hw/rtl/sgl_checker.sv]
// ----------------------------------------------------------------------------
// sgl_checker: port-level checks for the tone curve block
// Handshake and flow checks seen at the top-level ports.
// ----------------------------------------------------------------------------
module sgl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_red,
	input logic       out_fe
);

	// a stalled item stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("code_out.valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_red) && $stable(out_fe))
		else $error("code_out payload changed while stalled");

	// nothing comes out during reset
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("code_out.valid during reset");

	// with the output empty the pipe has room
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("pix_in stalled with empty output");

	// a taken output frees the pipe for a new item
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("pix_in stalled while output drains");

endmodule

bind split_gamma_levels_correction sgl_checker u_sgl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pix_in.ready),
	.out_valid (code_out.valid),
	.out_ready (code_out.ready),
	.out_red   (code_out.red_code),
	.out_fe    (code_out.frame_end_out)
);
